// ===== sv/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and opcodes for the multi-level priority FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
package mlpq_pkg;

   typedef enum logic [1:0] {
      MODE_PUSH      = 2'd0,
      MODE_POP_TOP   = 2'd1,
      MODE_POP_EXACT = 2'd2,
      MODE_POP_FLOOR = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  priority_req;
      logic [31:0] payload;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  out_priority;
      logic [31:0] out_payload;
      logic [10:0] occupancy;
   } rsp_word_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage : mlpq_pkg
`default_nettype wire

// ===== sv/mlpq_scan.sv =====
// ----------------------------------------------------------------------------
// mlpq_scan
// Non-empty flag vector per level and highest-set search at or above a floor.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_scan
   import mlpq_pkg::*;
#(
   parameter int LEVELS = 256
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      set_en,
   input  wire logic                      clr_en,
   input  wire logic [$clog2(LEVELS)-1:0] upd_lvl,
   input  wire logic [$clog2(LEVELS)-1:0] floor_lvl,
   input  wire logic                      start,
   output logic                           upd_nonempty,
   output logic                           found_ff,
   output logic [$clog2(LEVELS)-1:0]      found_lvl_ff
);
   localparam int LW = $clog2(LEVELS);

   logic [LEVELS-1:0] nonempty_ff;
   logic [LEVELS-1:0] masked;
   logic              hit;
   logic [LW-1:0]     hit_lvl;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
      end else begin
         if (set_en) nonempty_ff[upd_lvl] <= 1'b1;
         if (clr_en) nonempty_ff[upd_lvl] <= 1'b0;
      end
   end

   // level table contents only count while the level is marked non-empty
   assign upd_nonempty = nonempty_ff[upd_lvl];

   // priority encode from the top, one registered stage
   always_comb begin
      hit     = 1'b0;
      hit_lvl = '0;
      for (int i = 0; i < LEVELS; i++) begin
         masked[i] = nonempty_ff[i] && (LW'(i) >= floor_lvl);
         if (masked[i]) begin
            hit     = 1'b1;
            hit_lvl = LW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         found_ff     <= hit;
         found_lvl_ff <= hit_lvl;
      end
   end
endmodule : mlpq_scan
`default_nettype wire

// ===== sv/multilevel_priority_fifo_core.sv =====
// Push and exact pop pass through ST_READ, ST_WRITE and ST_RESP before a valid result,
// search pops through ST_SCAN first; one word in flight, so no word is taken until
// the result is taken. The search pops use the registered level priority encoder in ST_SCAN.
// After reset the free-list links are chained by a clearing pass over all CAPACITY
// entries, during which no request is accepted.
// Reset is synchronous and active high.
`default_nettype none
module multilevel_priority_fifo_core
   import mlpq_pkg::*;
#(
   parameter int LEVELS       = 256,
   parameter int CAPACITY     = 1024,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_word_type      rsp_word
);
   localparam int LW = $clog2(LEVELS);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // entry store: payload and link, one synchronous memory each
   logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];
   logic [AW-1:0]           next_mem [CAPACITY];
   // level table: head, tail and count packed into one memory word
   logic [AW+AW+CW-1:0]     lvl_mem [LEVELS];

   state_type state_ff, state_in;

   logic [1:0]              mode_ff;
   logic [7:0]              preq_ff;
   logic [PAYLOAD_BITS-1:0] wpay_ff;
   logic [LW-1:0]           lvl_ff, lvl_in;
   logic                    lvl_ok_ff, lvl_ok_in;
   logic [AW-1:0]           free_head_ff;
   logic [CW-1:0]           total_ff;
   logic [AW-1:0]           clr_ff;
   logic                    rsp_valid_ff;
   rsp_word_type            rsp_ff;

   // registered read data
   logic [AW+AW+CW-1:0]     lvl_rd_ff;
   logic [AW-1:0]           free_next_rd_ff;
   logic [AW-1:0]           head_next_rd_ff;
   logic [PAYLOAD_BITS-1:0] head_pay_rd_ff;

   // staged from ST_WRITE for the ST_RESP writes
   logic [AW-1:0]           lvl_tail_new_ff;
   logic                    pop_done_ff;
   logic                    push_link_ff;

   logic          scan_found;
   logic [LW-1:0] scan_lvl;
   logic          lvl_nonempty;
   logic          accept, nonempty_set, nonempty_clr;
   logic [AW-1:0] rd_head, rd_tail;
   logic [CW-1:0] rd_cnt, lvl_cnt;
   logic          is_push, do_op;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   assign rd_head = lvl_rd_ff[AW+AW+CW-1 -: AW];
   assign rd_tail = lvl_rd_ff[AW+CW-1 -: AW];
   assign rd_cnt  = lvl_rd_ff[CW-1:0];
   // a level never written reads as empty
   assign lvl_cnt = lvl_nonempty ? rd_cnt : '0;
   assign is_push = (mode_ff == MODE_PUSH);
   // the operation succeeds when its level is valid and it has something to do
   assign do_op = lvl_ok_ff && (is_push ? (total_ff < CW'(CAPACITY))
                                        : (lvl_cnt != '0));

   assign nonempty_set = (state_ff == ST_WRITE) && do_op && is_push;
   assign nonempty_clr = (state_ff == ST_WRITE) && do_op && !is_push &&
                         (lvl_cnt == CW'(1));

   mlpq_scan #(.LEVELS(LEVELS)) u_scan (
      .clock       (clock),
      .reset       (reset),
      .set_en      (nonempty_set),
      .clr_en      (nonempty_clr),
      .upd_lvl     (lvl_ff),
      .floor_lvl   ((mode_ff == MODE_POP_FLOOR) ? preq_ff[LW-1:0] : LW'(0)),
      .start       (state_ff == ST_SCAN),
      .upd_nonempty(lvl_nonempty),
      .found_ff    (scan_found),
      .found_lvl_ff(scan_lvl)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == AW'(CAPACITY - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_word.mode == MODE_POP_TOP || req_word.mode == MODE_POP_FLOOR)
                  state_in = ST_SCAN;
               else
                  state_in = ST_READ;
            end
         end
         ST_SCAN:  state_in = ST_READ;
         ST_READ:  state_in = ST_WRITE;
         ST_WRITE: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // level selection per state
   always_comb begin
      lvl_in    = lvl_ff;
      lvl_ok_in = lvl_ok_ff;
      unique case (state_ff)
         ST_IDLE: begin
            lvl_in    = req_word.priority_req[LW-1:0];
            lvl_ok_in = (9'(req_word.priority_req) < 9'(LEVELS));
         end
         ST_SCAN: begin
            lvl_in    = lvl_ff;
            lvl_ok_in = lvl_ok_ff;
         end
         ST_READ: begin
            // a floor beyond the top level finds nothing
            if (mode_ff == MODE_POP_TOP || mode_ff == MODE_POP_FLOOR) begin
               lvl_in    = scan_lvl;
               lvl_ok_in = scan_found && (mode_ff == MODE_POP_TOP || lvl_ok_ff);
            end
         end
         default: begin
            lvl_in    = lvl_ff;
            lvl_ok_in = lvl_ok_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         free_head_ff <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_RESP) rsp_valid_ff <= 1'b1;
         if (state_ff == ST_WRITE && do_op) begin
            if (is_push) begin
               free_head_ff <= free_next_rd_ff;
               total_ff     <= total_ff + CW'(1);
            end else begin
               free_head_ff <= rd_head;
               total_ff     <= total_ff - CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff    <= lvl_in;
      lvl_ok_ff <= lvl_ok_in;
      if (accept) begin
         mode_ff <= req_word.mode;
         preq_ff <= req_word.priority_req;
         wpay_ff <= req_word.payload[PAYLOAD_BITS-1:0];
      end
   end

   // level table: read in the cycle the level is known, write back once
   logic [LW-1:0] lvl_rd_addr;
   assign lvl_rd_addr = (state_ff == ST_READ &&
                         (mode_ff == MODE_POP_TOP || mode_ff == MODE_POP_FLOOR))
                        ? scan_lvl : lvl_ff;

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) lvl_rd_ff <= lvl_mem[lvl_rd_addr];
      if (state_ff == ST_WRITE && do_op && is_push) begin
         lvl_mem[lvl_ff] <= {(lvl_cnt == '0) ? free_head_ff : rd_head,
                             free_head_ff, lvl_cnt + CW'(1)};
      end else if (state_ff == ST_RESP && pop_done_ff) begin
         // the new head is the popped entry's link, read in ST_WRITE
         lvl_mem[lvl_ff] <= {head_next_rd_ff, rd_tail, rd_cnt - CW'(1)};
      end
   end

   // entry store reads: the free head link for push; the level head for pop.
   // The level head is only known after the level read, so pops read the head
   // entry in the following state, ST_WRITE, through the staging below.
   logic head_rd_pending_ff;
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) free_next_rd_ff <= next_mem[free_head_ff];
   end

   // For pops the head entry is read in ST_WRITE from the fresh level word;
   // the level table write of a pop happens in ST_RESP.
   always_ff @(posedge clock) begin
      head_rd_pending_ff <= (state_ff == ST_WRITE);
      if (state_ff == ST_WRITE) begin
         head_next_rd_ff <= next_mem[rd_head];
         head_pay_rd_ff  <= pay_mem[rd_head];
      end
   end

   // store writes: push and pop link return in ST_WRITE, tail link of a push in ST_RESP
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         next_mem[clr_ff] <= (clr_ff == AW'(CAPACITY - 1)) ? '0 : clr_ff + AW'(1);
      end else if (state_ff == ST_WRITE && do_op && is_push) begin
         next_mem[free_head_ff] <= '0;
         pay_mem[free_head_ff]  <= wpay_ff;
      end else if (state_ff == ST_WRITE && do_op && !is_push) begin
         next_mem[rd_head] <= free_head_ff;
      end else if (state_ff == ST_RESP && push_link_ff) begin
         next_mem[rd_tail] <= lvl_tail_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         lvl_tail_new_ff <= free_head_ff;
         pop_done_ff     <= do_op && !is_push;
         push_link_ff    <= do_op && is_push && (lvl_cnt != '0);
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (state_ff == ST_WRITE) begin
         rsp_ff.ok           <= do_op;
         rsp_ff.out_priority <= (do_op && !is_push) ? 8'(lvl_ff) : '0;
         rsp_ff.out_payload  <= '0;
         rsp_ff.occupancy    <= 11'(do_op ? (is_push ? total_ff + CW'(1)
                                                     : total_ff - CW'(1))
                                          : total_ff);
      end else if (state_ff == ST_RESP && pop_done_ff && head_rd_pending_ff) begin
         rsp_ff.out_payload <= 32'(head_pay_rd_ff);
      end
   end
endmodule : multilevel_priority_fifo_core
`default_nettype wire

// ===== sv/mlpq_checker.sv =====
// ----------------------------------------------------------------------------
// mlpq_checker
// Port-level checks for the multi-level priority FIFO.
// ----------------------------------------------------------------------------
`default_nettype none
module mlpq_checker
   import mlpq_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_word_type req_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_word_type rsp_word
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.ok |-> rsp_word.out_priority == '0 &&
                                    rsp_word.out_payload == '0)
      else $error("failed op carries data");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.occupancy <= 11'd1024)
      else $error("occupancy out of range");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with result pending");
endmodule : mlpq_checker

bind multilevel_priority_fifo_core mlpq_checker u_mlpq_checker (.*);
`default_nettype wire

// ===== tb/multilevel_priority_fifo_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_core_tb
// Drives push and pop words into the priority FIFO core, keeps a shadow of
// every level's queue and checks each response word against it in order.
// ----------------------------------------------------------------------------
`default_nettype none
module multilevel_priority_fifo_core_tb;
   import mlpq_pkg::*;

   localparam int NUM_LEVELS = 256;
   localparam int STORE_SIZE = 1024;
   localparam int WATCHDOG   = 20000;
   localparam int HOLD_LEN   = 300;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   multilevel_priority_fifo_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   // shadow queue state: one FIFO of payloads per level
   logic [31:0]  level_fifo[NUM_LEVELS][$];
   int           held_total;

   req_word_type pending_words[$];
   rsp_word_type expected_rsp[$];
   int           errors;
   int           pushes_sent, pops_sent, pops_ok, pushes_full;
   int           idle_cycles;
   logic         calm;          // no idling in the final stretch
   int           hold_cycles;   // long receiver hold-off
   logic         hold_done;
   int           req_gap, rsp_gap;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Predicts the response to one accepted word and updates the shadow.
   function automatic rsp_word_type predict_queue_op(req_word_type w);
      rsp_word_type r;
      int           lvl;
      r = '0;
      lvl = -1;
      case (mode_type'(w.mode))
         MODE_PUSH: begin
            if (held_total < STORE_SIZE) begin
               level_fifo[w.priority_req].push_back(w.payload);
               held_total++;
               r.ok = 1'b1;
            end
         end
         MODE_POP_EXACT: begin
            if (level_fifo[w.priority_req].size() > 0) lvl = w.priority_req;
         end
         default: begin
            // top pop searches down from the highest level, floor pop only down to the floor
            for (int p = NUM_LEVELS - 1; p >= 0; p--) begin
               if (lvl < 0 && level_fifo[p].size() > 0 &&
                   (w.mode == MODE_POP_TOP || p >= w.priority_req)) lvl = p;
            end
         end
      endcase
      if (w.mode != MODE_PUSH && lvl >= 0) begin
         r.ok = 1'b1;
         r.out_priority = lvl[7:0];
         r.out_payload = level_fifo[lvl].pop_front();
         held_total--;
      end
      r.occupancy = held_total[10:0];
      return r;
   endfunction

   // driver: valid never looks at stall; payload held while stalled
   always @(posedge clock) begin
      rsp_word_type pred;
      if (reset) begin
         req_valid <= 1'b0;
         req_word <= '0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            pred = predict_queue_op(req_word);
            expected_rsp.push_back(pred);
            if (req_word.mode == MODE_PUSH) begin
               pushes_sent++;
               if (!pred.ok) pushes_full++;
            end else begin
               pops_sent++;
               if (pred.ok) pops_ok++;
            end
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word <= pending_words.pop_front();
               req_valid <= 1'b1;
               if (!calm && $urandom_range(0, 9) == 0) req_gap <= $urandom_range(1, 8);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver-side stall
   always @(posedge clock) begin
      rsp_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap <= 0;
         hold_cycles <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: expected no response, actual %h", $time, rsp_word);
               errors++;
            end else begin
               exp_w = expected_rsp.pop_front();
               if (rsp_word.ok !== exp_w.ok) begin
                  $display("%0t: ok expected %b actual %b", $time, exp_w.ok, rsp_word.ok);
                  errors++;
               end
               if (rsp_word.out_priority !== exp_w.out_priority) begin
                  $display("%0t: priority expected %0d actual %0d", $time,
                           exp_w.out_priority, rsp_word.out_priority);
                  errors++;
               end
               if (rsp_word.out_payload !== exp_w.out_payload) begin
                  $display("%0t: payload expected %h actual %h", $time,
                           exp_w.out_payload, rsp_word.out_payload);
                  errors++;
               end
               if (rsp_word.occupancy !== exp_w.occupancy) begin
                  $display("%0t: occupancy expected %0d actual %0d", $time,
                           exp_w.occupancy, rsp_word.occupancy);
                  errors++;
               end
            end
         end
         // one long hold-off halfway through the fill while the sender keeps offering
         if (!hold_done && pushes_sent >= STORE_SIZE / 2) begin
            hold_done <= 1'b1;
            hold_cycles <= HOLD_LEN;
            rsp_stall <= 1'b1;
         end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_gap <= $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: cycles without any accepted word or taken response
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("multilevel_priority_fifo_core verification failed");
         $finish;
      end
   end

   function automatic req_word_type make_word(mode_type m, int lvl, logic [31:0] d);
      req_word_type w;
      w.mode = m;
      w.priority_req = lvl[7:0];
      w.payload = d;
      return w;
   endfunction

   task automatic add_random_words(int n, int hot_lo, int hot_hi);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         // pushes take half of the words so levels fill; hot range keeps collisions
         if (k < 50)
            pending_words.push_back(make_word(MODE_PUSH,
               (k < 40) ? $urandom_range(hot_lo, hot_hi) : $urandom_range(0, 255),
               $urandom()));
         else if (k < 65)
            pending_words.push_back(make_word(MODE_POP_TOP, $urandom_range(0, 255),
                                              $urandom()));
         else if (k < 82)
            pending_words.push_back(make_word(MODE_POP_EXACT,
               (k < 78) ? $urandom_range(hot_lo, hot_hi) : $urandom_range(0, 255),
               $urandom()));
         else
            pending_words.push_back(make_word(MODE_POP_FLOOR,
               $urandom_range(hot_lo, hot_hi), $urandom()));
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pops, extreme levels and payloads, FIFO order, floor
      pending_words.push_back(make_word(MODE_POP_TOP, 0, '1));
      pending_words.push_back(make_word(MODE_POP_EXACT, 255, 0));
      pending_words.push_back(make_word(MODE_POP_FLOOR, 0, 0));
      pending_words.push_back(make_word(MODE_PUSH, 0, 32'h0000_0000));
      pending_words.push_back(make_word(MODE_PUSH, 255, 32'hFFFF_FFFF));
      pending_words.push_back(make_word(MODE_PUSH, 255, 32'hA5A5_5A5A));
      pending_words.push_back(make_word(MODE_PUSH, 100, 32'h5A5A_A5A5));
      pending_words.push_back(make_word(MODE_POP_FLOOR, 255, 0));
      pending_words.push_back(make_word(MODE_POP_TOP, 0, 0));
      pending_words.push_back(make_word(MODE_POP_FLOOR, 101, 0));
      pending_words.push_back(make_word(MODE_POP_FLOOR, 100, 0));
      pending_words.push_back(make_word(MODE_POP_EXACT, 100, 0));
      pending_words.push_back(make_word(MODE_POP_EXACT, 0, 0));
      pending_words.push_back(make_word(MODE_POP_TOP, 0, 0));
      wait_drained();

      // fill the store to capacity, try pushes into a full store, then pop some
      for (int i = 0; i < STORE_SIZE; i++)
         pending_words.push_back(make_word(MODE_PUSH, $urandom_range(0, 3), $urandom()));
      pending_words.push_back(make_word(MODE_PUSH, 255, '1));
      pending_words.push_back(make_word(MODE_PUSH, 0, 0));
      for (int i = 0; i < 60; i++)
         pending_words.push_back(make_word(MODE_POP_TOP, 0, 0));
      wait_drained();

      add_random_words(50, 0, 7);
      add_random_words(50, 248, 255);
      wait_drained();
      calm = 1'b1;
      add_random_words(50, 0, 255);
      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sent %0d pushes (%0d refused on a full store) and %0d pops (%0d found an entry),",
               pushes_sent, pushes_full, pops_sent, pops_ok);
      $display("over all four modes, empty levels, a full store and a long response hold-off.");
      if (errors == 0)
         $display("multilevel_priority_fifo_core verification clean");
      else
         $display("multilevel_priority_fifo_core verification failed");
      $finish;
   end
endmodule
`default_nettype wire
